// File: hw/rtl/assert_macros.svh
// assertion macros shared by the ips patch decoder rtl
// no dependencies; assertions compile out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

// File: hw/rtl/ipsd_pkg.sv
// types, constants and helpers for the ips patch stream decoder
// no dependencies; used by every rtl module of the block
`default_nettype none

package ipsd_pkg;

  localparam int ADDR_W  = 25;
  localparam int OFF_W   = 24;
  localparam int CNT_W   = 16;
  localparam int BYTE_W  = 8;
  localparam int POS_W   = 3;

  localparam logic [POS_W-1:0] SIG_LAST  = 3'd4;
  localparam logic [POS_W-1:0] SIG_LEN   = 3'd5;
  localparam logic [POS_W-1:0] OFF_BYTES = 3'd3;
  localparam logic [POS_W-1:0] LEN_BYTES = 3'd2;
  localparam logic [OFF_W-1:0] EOF_TAG   = 24'h454F46;

  // result queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;
  localparam logic [QCNT_W-1:0] QFULL = QCNT_W'(QDEPTH);
  localparam logic [QPTR_W-1:0] QPTR_ONE = QPTR_W'(1);
  localparam logic [QCNT_W-1:0] QCNT_ONE = QCNT_W'(1);

  typedef enum logic [2:0] {
    PH_SIG  = 3'd0,
    PH_OFF  = 3'd1,
    PH_LEN  = 3'd2,
    PH_RCNT = 3'd3,
    PH_RVAL = 3'd4,
    PH_DATA = 3'd5,
    PH_DONE = 3'd6,
    PH_ERR  = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    KIND_CMD    = 2'd0,
    KIND_END    = 2'd1,
    KIND_BADSIG = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] value;
    logic [CNT_W-1:0]  count;
  } result_t;

  // expected signature byte at a position, zero beyond it
  function automatic logic [BYTE_W-1:0] sig_byte(input logic [POS_W-1:0] pos);
    logic [BYTE_W-1:0] b;
    case (pos)
      3'd0:    b = 8'h50;
      3'd1:    b = 8'h41;
      3'd2:    b = 8'h54;
      3'd3:    b = 8'h43;
      3'd4:    b = 8'h48;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ipsd_front.sv
// front end: accepts patch bytes, runs the record parser, pushes commands
// depends on ipsd_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module ipsd_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [ipsd_pkg::BYTE_W-1:0] patch_byte_i,
  input  wire logic                        file_start_i,
  input  wire logic                        q_full_i,
  output logic                             push_o,
  output ipsd_pkg::result_t                push_data_o
);

  ipsd_pkg::phase_e phase_q, phase_d, phase_c;
  logic [ipsd_pkg::POS_W-1:0]  pos_q, pos_d, pos_c, pos_inc;
  logic [ipsd_pkg::OFF_W-1:0]  off_q, off_d, off_c, off_sh;
  logic [ipsd_pkg::CNT_W-1:0]  len_q, len_d, len_c, len_sh;
  logic [ipsd_pkg::CNT_W-1:0]  left_q, left_d, left_c, left_sh, left_dec;
  logic [ipsd_pkg::ADDR_W-1:0] wptr_q, wptr_d, wptr_c;
  logic                        accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !in_stall_o;

  // a start flag restarts the parser before the byte is taken
  assign phase_c = file_start_i ? ipsd_pkg::PH_SIG : phase_q;
  assign pos_c   = file_start_i ? '0 : pos_q;
  assign off_c   = file_start_i ? '0 : off_q;
  assign len_c   = file_start_i ? '0 : len_q;
  assign left_c  = file_start_i ? '0 : left_q;
  assign wptr_c  = file_start_i ? '0 : wptr_q;

  assign pos_inc  = pos_c + 3'd1;
  assign off_sh   = {off_c[ipsd_pkg::OFF_W-9:0], patch_byte_i};
  assign len_sh   = {len_c[ipsd_pkg::CNT_W-9:0], patch_byte_i};
  assign left_sh  = {left_c[ipsd_pkg::CNT_W-9:0], patch_byte_i};
  assign left_dec = left_c - 16'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ipsd_pkg::PH_SIG;
      pos_q   <= '0;
      off_q   <= '0;
      len_q   <= '0;
      left_q  <= '0;
      wptr_q  <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      off_q   <= off_d;
      len_q   <= len_d;
      left_q  <= left_d;
      wptr_q  <= wptr_d;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    off_d       = off_q;
    len_d       = len_q;
    left_d      = left_q;
    wptr_d      = wptr_q;
    push_o      = 1'b0;
    push_data_o = '{kind: ipsd_pkg::KIND_CMD, addr: '0, value: '0, count: '0};
    if (accept) begin
      phase_d = phase_c;
      pos_d   = pos_c;
      off_d   = off_c;
      len_d   = len_c;
      left_d  = left_c;
      wptr_d  = wptr_c;
      case (phase_c)
        ipsd_pkg::PH_SIG: begin
          if (pos_c > ipsd_pkg::SIG_LAST || patch_byte_i != ipsd_pkg::sig_byte(pos_c)) begin
            push_o           = 1'b1;
            push_data_o.kind = ipsd_pkg::KIND_BADSIG;
            phase_d          = ipsd_pkg::PH_ERR;
            pos_d            = '0;
          end else if (pos_inc == ipsd_pkg::SIG_LEN) begin
            pos_d   = '0;
            off_d   = '0;
            phase_d = ipsd_pkg::PH_OFF;
          end else begin
            pos_d = pos_inc;
          end
        end
        ipsd_pkg::PH_OFF: begin
          off_d = off_sh;
          pos_d = pos_inc;
          if (pos_inc >= ipsd_pkg::OFF_BYTES) begin
            pos_d = '0;
            if (off_sh == ipsd_pkg::EOF_TAG) begin
              push_o           = 1'b1;
              push_data_o.kind = ipsd_pkg::KIND_END;
              phase_d          = ipsd_pkg::PH_DONE;
            end else begin
              len_d   = '0;
              phase_d = ipsd_pkg::PH_LEN;
            end
          end
        end
        ipsd_pkg::PH_LEN: begin
          len_d = len_sh;
          pos_d = pos_inc;
          if (pos_inc >= ipsd_pkg::LEN_BYTES) begin
            pos_d = '0;
            if (len_sh == '0) begin
              left_d  = '0;
              phase_d = ipsd_pkg::PH_RCNT;
            end else begin
              left_d  = len_sh;
              wptr_d  = {1'b0, off_c};
              phase_d = ipsd_pkg::PH_DATA;
            end
          end
        end
        ipsd_pkg::PH_RCNT: begin
          left_d = left_sh;
          pos_d  = pos_inc;
          if (pos_inc >= ipsd_pkg::LEN_BYTES) begin
            pos_d   = '0;
            phase_d = ipsd_pkg::PH_RVAL;
          end
        end
        ipsd_pkg::PH_RVAL: begin
          // a run with a zero count writes nothing
          if (left_c != '0) begin
            push_o            = 1'b1;
            push_data_o.addr  = {1'b0, off_c};
            push_data_o.value = patch_byte_i;
            push_data_o.count = left_c;
          end
          left_d  = '0;
          off_d   = '0;
          pos_d   = '0;
          phase_d = ipsd_pkg::PH_OFF;
        end
        ipsd_pkg::PH_DATA: begin
          push_o            = 1'b1;
          push_data_o.addr  = wptr_c;
          push_data_o.value = patch_byte_i;
          push_data_o.count = 16'd1;
          wptr_d            = wptr_c + 25'd1;
          left_d            = left_dec;
          if (left_dec == '0) begin
            off_d   = '0;
            pos_d   = '0;
            phase_d = ipsd_pkg::PH_OFF;
          end
        end
        default: begin
        end
      endcase
    end
  end

  `ASSERT_NEVER(a_push_needs_accept, clk_i, rst_ni, push_o && !accept)
  `ASSERT_PROP(a_err_sticks, clk_i, rst_ni,
    (phase_q == ipsd_pkg::PH_ERR && !(accept && file_start_i)) |=> phase_q == ipsd_pkg::PH_ERR)

endmodule

`default_nettype wire

// File: hw/rtl/ipsd_queue.sv
// short result queue between the parser and the output stage
// depends on ipsd_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module ipsd_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire ipsd_pkg::result_t  push_data_i,
  output logic                    full_o,
  input  wire logic               pop_i,
  output logic                    valid_o,
  output ipsd_pkg::result_t       data_o
);

  ipsd_pkg::result_t                 mem_q [ipsd_pkg::QDEPTH];
  logic [ipsd_pkg::QPTR_W-1:0]       wr_q, wr_d, rd_q, rd_d;
  logic [ipsd_pkg::QCNT_W-1:0]       cnt_q, cnt_d;
  logic                              do_push, do_pop;

  assign full_o  = (cnt_q == ipsd_pkg::QFULL);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = do_push ? wr_q + ipsd_pkg::QPTR_ONE : wr_q;
    rd_d  = do_pop ? rd_q + ipsd_pkg::QPTR_ONE : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + ipsd_pkg::QCNT_ONE;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - ipsd_pkg::QCNT_ONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  `ASSERT_NEVER(a_no_push_when_full, clk_i, rst_ni, push_i && full_o)

endmodule

`default_nettype wire

// File: hw/rtl/ipsd_back.sv
// back end: output register that takes commands from the queue
// depends on ipsd_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module ipsd_back (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         q_valid_i,
  input  wire ipsd_pkg::result_t            q_data_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [1:0]                        kind_o,
  output logic [ipsd_pkg::ADDR_W-1:0]       target_address_o,
  output logic [ipsd_pkg::BYTE_W-1:0]       fill_value_o,
  output logic [ipsd_pkg::CNT_W-1:0]        repeat_count_o
);

  logic              valid_q, valid_d;
  ipsd_pkg::result_t data_q;

  // refill the register when it is empty or its transaction completes now
  assign pop_o = q_valid_i && (!valid_q || !out_stall_i);

  always_comb begin
    valid_d = valid_q;
    if (pop_o) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= q_data_i;
    end
  end

  assign out_valid_o      = valid_q;
  assign kind_o           = data_q.kind;
  assign target_address_o = data_q.addr;
  assign fill_value_o     = data_q.value;
  assign repeat_count_o   = data_q.count;

  `ASSERT_PROP(a_pop_fills_reg, clk_i, rst_ni, pop_o |=> valid_q)

endmodule

`default_nettype wire

// File: hw/rtl/ips_patch_stream_decoder_top.sv
// ips patch stream decoder: the block's top level
// depends on ipsd_pkg, ipsd_front, ipsd_queue and ipsd_back
//
// usage:
//   input channel: in_valid_i / in_stall_o carry one patch byte per transaction,
//   with file_start_i raised on the first byte of a new file (that byte is
//   parsed as the first signature byte).
//   output channel: out_valid_o / out_stall_i carry one command per transaction:
//   kind 0 is a write or fill (address, value, count), 1 the end tag, 2 a bad
//   signature. Bytes that complete nothing give no output transaction.
//   throughput: one byte per cycle while in_stall_o is low; each byte is parsed in
//   the cycle it is accepted, so no byte depends on a later result.
//   path: a command is pushed into a four-entry queue at the edge that accepts
//   its byte, then moved into the output register once that register is empty
//   or its command is taken.
//   stalls: while the receiver stalls, the output register holds its command
//   and the queue fills; in_stall_o rises once the queue is full.
//   reset: the parser returns to the signature phase, the queue empties and
//   out_valid_o drops.
`default_nettype none

module ips_patch_stream_decoder_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [ipsd_pkg::BYTE_W-1:0]  patch_byte_i,
  input  wire logic                         file_start_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [1:0]                        kind_o,
  output logic [ipsd_pkg::ADDR_W-1:0]       target_address_o,
  output logic [ipsd_pkg::BYTE_W-1:0]       fill_value_o,
  output logic [ipsd_pkg::CNT_W-1:0]        repeat_count_o
);

  logic              push, q_full, q_valid, pop;
  ipsd_pkg::result_t push_data, q_data;

  ipsd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .patch_byte_i (patch_byte_i),
    .file_start_i (file_start_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  ipsd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .data_o      (q_data)
  );

  ipsd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_data_i         (q_data),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_o           (kind_o),
    .target_address_o (target_address_o),
    .fill_value_o     (fill_value_o),
    .repeat_count_o   (repeat_count_o)
  );

endmodule

`default_nettype wire

// File: tb/sv/tb_ips_patch_stream_decoder_top.sv
// testbench for the ips patch stream decoder: directed files, then random patch streams
// depends on ipsd_pkg and ips_patch_stream_decoder_top; commands checked against a parser model
`timescale 1ns / 100ps

module tb_ips_patch_stream_decoder_top;

  localparam logic [39:0] SIG_TEXT = 40'h5041544348;  // "PATCH"
  localparam int RANDOM_BYTES = 1600;
  localparam int MAX_SHOWN = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [7:0] patch_byte = 8'h00;
  logic file_start = 1'b0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  logic [1:0] kind;
  logic [ipsd_pkg::ADDR_W-1:0] target_address;
  logic [7:0] fill_value;
  logic [ipsd_pkg::CNT_W-1:0] repeat_count;

  // parser model state
  ipsd_pkg::phase_e parse_ph;
  logic [2:0] field_pos;
  logic [23:0] rec_offset;
  logic [15:0] rec_length;
  logic [15:0] left_count;
  logic [24:0] wr_ptr;

  ipsd_pkg::result_t pending_cmds[$];
  ipsd_pkg::result_t due_cmd;
  int mismatch_cnt = 0;
  int parsed_bytes = 0;
  int stall_left = 0;
  bit quiet = 1'b0;

  ips_patch_stream_decoder_top uut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_valid_i(in_valid),
    .in_stall_o(in_stall),
    .patch_byte_i(patch_byte),
    .file_start_i(file_start),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .kind_o(kind),
    .target_address_o(target_address),
    .fill_value_o(fill_value),
    .repeat_count_o(repeat_count)
  );

  always #1 clk = ~clk;

  initial begin
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void queue_cmd(input ipsd_pkg::kind_e k, input logic [24:0] a,
                                    input logic [7:0] v, input logic [15:0] c);
    ipsd_pkg::result_t r;
    r.kind = k;
    r.addr = a;
    r.value = v;
    r.count = c;
    pending_cmds.push_back(r);
  endfunction

  function automatic void clear_parser();
    parse_ph = ipsd_pkg::PH_SIG;
    field_pos = '0;
    rec_offset = '0;
    rec_length = '0;
    left_count = '0;
    wr_ptr = '0;
  endfunction

  function automatic void parse_patch_byte(input logic [7:0] b, input logic st);
    if (st) clear_parser();
    if (parse_ph != ipsd_pkg::PH_DONE && parse_ph != ipsd_pkg::PH_ERR) parsed_bytes++;
    case (parse_ph)
      ipsd_pkg::PH_SIG: begin
        if (field_pos > ipsd_pkg::SIG_LAST || b != SIG_TEXT[39 - 8*field_pos -: 8]) begin
          queue_cmd(ipsd_pkg::KIND_BADSIG, '0, '0, '0);
          parse_ph = ipsd_pkg::PH_ERR;
          field_pos = '0;
        end else begin
          field_pos++;
          if (field_pos == ipsd_pkg::SIG_LEN) begin
            field_pos = '0;
            rec_offset = '0;
            parse_ph = ipsd_pkg::PH_OFF;
          end
        end
      end
      ipsd_pkg::PH_OFF: begin
        rec_offset = {rec_offset[15:0], b};
        field_pos++;
        if (field_pos >= ipsd_pkg::OFF_BYTES) begin
          field_pos = '0;
          if (rec_offset == ipsd_pkg::EOF_TAG) begin
            queue_cmd(ipsd_pkg::KIND_END, '0, '0, '0);
            parse_ph = ipsd_pkg::PH_DONE;
          end else begin
            rec_length = '0;
            parse_ph = ipsd_pkg::PH_LEN;
          end
        end
      end
      ipsd_pkg::PH_LEN: begin
        rec_length = {rec_length[7:0], b};
        field_pos++;
        if (field_pos >= ipsd_pkg::LEN_BYTES) begin
          field_pos = '0;
          if (rec_length == 16'h0000) begin
            left_count = '0;
            parse_ph = ipsd_pkg::PH_RCNT;
          end else begin
            left_count = rec_length;
            wr_ptr = {1'b0, rec_offset};
            parse_ph = ipsd_pkg::PH_DATA;
          end
        end
      end
      ipsd_pkg::PH_RCNT: begin
        left_count = {left_count[7:0], b};
        field_pos++;
        if (field_pos >= ipsd_pkg::LEN_BYTES) begin
          field_pos = '0;
          parse_ph = ipsd_pkg::PH_RVAL;
        end
      end
      ipsd_pkg::PH_RVAL: begin
        // a run of zero length writes nothing
        if (left_count != 16'h0000)
          queue_cmd(ipsd_pkg::KIND_CMD, {1'b0, rec_offset}, b, left_count);
        left_count = '0;
        rec_offset = '0;
        field_pos = '0;
        parse_ph = ipsd_pkg::PH_OFF;
      end
      ipsd_pkg::PH_DATA: begin
        queue_cmd(ipsd_pkg::KIND_CMD, wr_ptr, b, 16'd1);
        wr_ptr++;
        left_count--;
        if (left_count == 16'h0000) begin
          rec_offset = '0;
          field_pos = '0;
          parse_ph = ipsd_pkg::PH_OFF;
        end
      end
      default: ;
    endcase
  endfunction

  // input transactions feed the model first, then the output transaction is checked
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) parse_patch_byte(patch_byte, file_start);
    if (rst_n && out_valid && !out_stall) begin
      if (pending_cmds.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_SHOWN)
          $display("unexpected command: kind %0d addr %h value %h count %h",
                   kind, target_address, fill_value, repeat_count);
      end else begin
        due_cmd = pending_cmds.pop_front();
        if (kind !== due_cmd.kind || target_address !== due_cmd.addr ||
            fill_value !== due_cmd.value || repeat_count !== due_cmd.count) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_SHOWN)
            $display("mismatch: kind %0d/%0d addr %h/%h value %h/%h count %h/%h (exp/got)",
                     due_cmd.kind, kind, due_cmd.addr, target_address,
                     due_cmd.value, fill_value, due_cmd.count, repeat_count);
        end
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if (!quiet && $urandom_range(0, 3) == 0) stall_left = idle_len();
    end
  end

  // one input transaction; called and returns at a falling edge
  task automatic push_byte(input logic [7:0] b, input logic st);
    int gap;
    in_valid <= 1'b1;
    patch_byte <= b;
    file_start <= st;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    gap = quiet ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // big-endian field of n bytes
  task automatic send_field(input logic [23:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) push_byte(v[8*i +: 8], 1'b0);
  endtask

  task automatic send_signature(input logic st);
    for (int i = 0; i < 5; i++) push_byte(SIG_TEXT[39 - 8*i -: 8], st && i == 0);
  endtask

  task automatic test_no_start_after_reset();
    send_signature(1'b0);
    send_field(24'hFFFFFF, 3);
    send_field(24'h000001, 2);
    push_byte(8'h00, 1'b0);
    // run record with zero count
    send_field(24'h000000, 3);
    send_field(24'h000000, 2);
    send_field(24'h000000, 2);
    push_byte(8'hFF, 1'b0);
    send_field(ipsd_pkg::EOF_TAG, 3);
  endtask

  task automatic test_bad_signature();
    push_byte(8'h50, 1'b1);
    push_byte(8'h41, 1'b0);
    push_byte(8'h54, 1'b0);
    push_byte(8'h43, 1'b0);
    push_byte(8'h58, 1'b0);
    push_byte(8'h48, 1'b0);  // ignored after the error
    push_byte(8'h51, 1'b1);
  endtask

  task automatic test_random_files();
    int pick;
    int rec_kind;
    int nrec;
    int pos;
    int len;
    int cut;
    logic [7:0] bad;
    logic [23:0] offs;
    logic [15:0] cnt;
    bit truncated;
    while (parsed_bytes < RANDOM_BYTES) begin
      quiet = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        // noise
        push_byte(8'($urandom), 1'($urandom));
        repeat ($urandom_range(0, 10)) push_byte(8'($urandom), 1'b0);
      end else if (pick < 15) begin
        pos = $urandom_range(0, 4);
        bad = 8'($urandom);
        if (bad == SIG_TEXT[39 - 8*pos -: 8]) bad ^= 8'h01 << $urandom_range(0, 7);
        for (int i = 0; i < pos; i++) push_byte(SIG_TEXT[39 - 8*i -: 8], i == 0);
        push_byte(bad, pos == 0);
        repeat ($urandom_range(0, 3)) push_byte(8'($urandom), 1'b0);
      end else begin
        send_signature(1'b1);
        nrec = $urandom_range(0, 6);
        truncated = 1'b0;
        for (int r = 0; r < nrec && !truncated; r++) begin
          rec_kind = $urandom_range(0, 99);
          offs = 24'($urandom);
          if (rec_kind % 9 == 0) offs = 24'h000000;
          if (rec_kind % 9 == 1) offs = 24'hFFFFFF;
          if (offs == ipsd_pkg::EOF_TAG) offs = 24'h454F47;
          send_field(offs, 3);
          if (rec_kind < 60) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            send_field(24'(len), 2);
            repeat (len) push_byte(8'($urandom), 1'b0);
          end else if (rec_kind < 66) begin
            // record cut short, the next file restarts the parser
            len = $urandom_range(1, 65535);
            cut = $urandom_range(0, 8);
            if (cut < 2) send_field(24'(len >> 8), 1);
            else begin
              send_field(24'(len), 2);
              for (int i = 2; i < cut && i - 2 < len; i++) push_byte(8'($urandom), 1'b0);
            end
            truncated = 1'b1;
          end else begin
            case ($urandom_range(0, 9))
              0, 1: cnt = 16'h0000;
              2: cnt = 16'hFFFF;
              3: cnt = 16'h0001;
              default: cnt = 16'($urandom);
            endcase
            send_field(24'h000000, 2);
            send_field({8'h00, cnt}, 2);
            push_byte(8'($urandom), 1'b0);
          end
        end
        if (!truncated && $urandom_range(0, 9) != 0) begin
          send_field(ipsd_pkg::EOF_TAG, 3);
          repeat ($urandom_range(0, 2)) push_byte(8'($urandom), 1'b0);
        end
      end
    end
  endtask

  initial begin
    clear_parser();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_no_start_after_reset();
    test_bad_signature();
    test_random_files();
    in_valid <= 1'b0;
    quiet = 1'b1;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0 && pending_cmds.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
